// ===== rtl/wstpo_pkg.sv =====
// shared types, codes and sizes for the weighted slot table
package wstpo_pkg;

  localparam int unsigned SlotsDefault = 64;
  localparam int unsigned IdW          = 64;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned SlotIdxW     = 7;
  localparam int unsigned StatusW      = 3;

  typedef enum logic [1:0] {
    FUNC_ATTACH   = 2'd0,
    FUNC_DETACH   = 2'd1,
    FUNC_SET_WT   = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_e;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_ALREADY = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd2;
  localparam logic [StatusW-1:0] ST_ABSENT  = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [IdW-1:0]     group_id;
    logic [WeightW-1:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [SlotIdxW-1:0] slot_index;
    logic [IdW-1:0]      slot_group_id;
    logic                last;
  } out_word_t;

  // classified command from front to back
  typedef struct packed {
    func_e              op;
    logic [IdW-1:0]     gid;
    logic [WeightW-1:0] weight;
    logic               gid_zero;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RES,
    BK_DRES
  } back_state_e;

endpackage

// ===== rtl/wstpo_ram.sv =====
// generic single write, single registered read RAM
module wstpo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/wstpo_front.sv =====
// front end: accepts words, classifies them and queues up to two commands
module wstpo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  wstpo_pkg::in_word_t in_word_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output wstpo_pkg::cmd_t   cmd_o
);

  wstpo_pkg::cmd_t fifo_q [2];
  wstpo_pkg::cmd_t cmd_in;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  // classify the incoming word
  always_comb begin
    cmd_in.op       = wstpo_pkg::func_e'(in_word_i.func);
    cmd_in.gid      = in_word_i.group_id;
    cmd_in.weight   = in_word_i.weight;
    cmd_in.gid_zero = (in_word_i.group_id == '0);
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== rtl/wstpo_back.sv =====
// back end: scans the slot table, applies edits and emits dispatch order
module wstpo_back #(
  parameter int unsigned Slots = wstpo_pkg::SlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wstpo_pkg::cmd_t      cmd_i,
  output logic                 empty,
  input  logic                 pop,
  output wstpo_pkg::out_word_t out_word_o
);

  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned IdW = wstpo_pkg::IdW;
  localparam int unsigned WtW = wstpo_pkg::WeightW;
  localparam int unsigned XW  = wstpo_pkg::SlotIdxW;
  localparam logic [XW-1:0] IdxNone = XW'(Slots);
  localparam logic [CW-1:0] CntEnd  = CW'(Slots);

  wstpo_pkg::back_state_e state_q, state_d;
  wstpo_pkg::cmd_t        cmd_q;
  wstpo_pkg::out_word_t   out_q, res;

  logic [CW-1:0]    cnt_q, occ_cnt_q, k_q;
  logic             chk_vld_q;
  logic [IW-1:0]    chk_idx_q;
  logic [Slots-1:0] occ_q;
  logic             hit_q, free_vld_q, first_q, best_vld_q, out_vld_q;
  logic [IW-1:0]    hit_idx_q, free_idx_q, lidx_q, best_idx_q;
  logic [WtW-1:0]   lw_q, best_w_q;
  logic [IdW-1:0]   best_id_q;

  logic [IdW-1:0]   id_rdata;
  logic [WtW-1:0]   wt_rdata;
  logic             take, issue, scan_done, out_free, emit, last_hit;
  logic             id_we, wt_we, occ_set, occ_clr;
  logic [IW-1:0]    wr_idx;
  logic             chk_occ, cand, better;

  // table memories
  wstpo_ram #(.Width(IdW), .Depth(Slots)) u_id_ram (
    .clk_i, .we_i(id_we), .waddr_i(wr_idx), .wdata_i(cmd_q.gid),
    .raddr_i(cnt_q[IW-1:0]), .rdata_o(id_rdata)
  );

  wstpo_ram #(.Width(WtW), .Depth(Slots)) u_wt_ram (
    .clk_i, .we_i(wt_we), .waddr_i(wr_idx), .wdata_i(cmd_q.weight),
    .raddr_i(cnt_q[IW-1:0]), .rdata_o(wt_rdata)
  );

  assign out_free  = !out_vld_q || pop;
  assign empty     = !out_vld_q;
  assign out_word_o = out_q;
  assign last_hit  = (CW'(k_q + 1'b1) == occ_cnt_q);

  // compare stage on the slot read in the previous cycle
  assign chk_occ = occ_q[chk_idx_q];
  assign cand    = chk_occ && (first_q || (wt_rdata < lw_q) ||
                   ((wt_rdata == lw_q) && (chk_idx_q > lidx_q)));
  assign better  = cand && (!best_vld_q || (wt_rdata > best_w_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wstpo_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == wstpo_pkg::FUNC_DISPATCH) begin
            state_d = (occ_cnt_q == '0) ? wstpo_pkg::BK_DRES : wstpo_pkg::BK_SCAN;
          end else begin
            state_d = cmd_i.gid_zero ? wstpo_pkg::BK_RES : wstpo_pkg::BK_SCAN;
          end
        end
      end
      wstpo_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_d = (cmd_q.op == wstpo_pkg::FUNC_DISPATCH) ? wstpo_pkg::BK_DRES
                                                            : wstpo_pkg::BK_RES;
        end
      end
      wstpo_pkg::BK_RES: begin
        if (out_free) state_d = wstpo_pkg::BK_IDLE;
      end
      wstpo_pkg::BK_DRES: begin
        if (out_free) begin
          state_d = (!best_vld_q || last_hit) ? wstpo_pkg::BK_IDLE : wstpo_pkg::BK_SCAN;
        end
      end
      default: state_d = wstpo_pkg::BK_IDLE;
    endcase
  end

  // control outputs and result word
  always_comb begin
    take      = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    emit      = 1'b0;
    id_we     = 1'b0;
    wt_we     = 1'b0;
    occ_set   = 1'b0;
    occ_clr   = 1'b0;
    wr_idx    = hit_idx_q;
    res.status        = wstpo_pkg::ST_OK;
    res.slot_index    = IdxNone;
    res.slot_group_id = '0;
    res.last          = 1'b1;
    case (state_q)
      wstpo_pkg::BK_IDLE: begin
        take = cmd_valid_i;
      end
      wstpo_pkg::BK_SCAN: begin
        issue     = (cnt_q < CntEnd);
        scan_done = !issue && !chk_vld_q;
      end
      wstpo_pkg::BK_RES: begin
        emit = out_free;
        case (cmd_q.op)
          wstpo_pkg::FUNC_ATTACH: begin
            if (cmd_q.gid_zero) begin
              res.status = wstpo_pkg::ST_ALREADY;
            end else if (hit_q) begin
              res.status     = wstpo_pkg::ST_ALREADY;
              res.slot_index = XW'(hit_idx_q);
            end else if (!free_vld_q) begin
              res.status = wstpo_pkg::ST_FULL;
            end else begin
              res.slot_index = XW'(free_idx_q);
              wr_idx  = free_idx_q;
              id_we   = out_free;
              wt_we   = out_free;
              occ_set = out_free;
            end
          end
          wstpo_pkg::FUNC_DETACH: begin
            if (hit_q) begin
              res.slot_index = XW'(hit_idx_q);
              occ_clr = out_free;
            end else begin
              res.status = wstpo_pkg::ST_ABSENT;
            end
          end
          wstpo_pkg::FUNC_SET_WT: begin
            if (hit_q) begin
              res.slot_index = XW'(hit_idx_q);
              wt_we = out_free;
            end else begin
              res.status = wstpo_pkg::ST_ABSENT;
            end
          end
          default: begin
            res.status = wstpo_pkg::ST_ABSENT;
          end
        endcase
      end
      wstpo_pkg::BK_DRES: begin
        emit = out_free;
        if (best_vld_q) begin
          res.slot_index    = XW'(best_idx_q);
          res.slot_group_id = best_id_q;
          res.last          = last_hit;
        end else begin
          res.status = wstpo_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready_o = take;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    if (emit) out_q <= res;
    chk_idx_q <= cnt_q[IW-1:0];
  end

  // sequencer and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wstpo_pkg::BK_IDLE;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      occ_q      <= '0;
      occ_cnt_q  <= '0;
      k_q        <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_vld_q <= 1'b0;
      free_idx_q <= '0;
      first_q    <= 1'b1;
      lw_q       <= '0;
      lidx_q     <= '0;
      best_vld_q <= 1'b0;
      best_w_q   <= '0;
      best_idx_q <= '0;
      best_id_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= issue;
      if (issue) cnt_q <= cnt_q + 1'b1;

      // start of a command
      if (take) begin
        cnt_q      <= '0;
        hit_q      <= 1'b0;
        free_vld_q <= 1'b0;
        best_vld_q <= 1'b0;
        first_q    <= 1'b1;
        k_q        <= '0;
      end

      // compare the slot just read
      if (chk_vld_q) begin
        if (chk_occ && (id_rdata == cmd_q.gid)) begin
          hit_q     <= 1'b1;
          hit_idx_q <= chk_idx_q;
        end
        if (!chk_occ && !free_vld_q) begin
          free_vld_q <= 1'b1;
          free_idx_q <= chk_idx_q;
        end
        if (better) begin
          best_vld_q <= 1'b1;
          best_w_q   <= wt_rdata;
          best_idx_q <= chk_idx_q;
          best_id_q  <= id_rdata;
        end
      end

      // occupancy bookkeeping
      if (occ_set) begin
        occ_q[wr_idx] <= 1'b1;
        occ_cnt_q     <= occ_cnt_q + 1'b1;
      end
      if (occ_clr) begin
        occ_q[wr_idx] <= 1'b0;
        occ_cnt_q     <= occ_cnt_q - 1'b1;
      end

      // next dispatch pass starts below the slot just emitted
      if (emit && state_q == wstpo_pkg::BK_DRES) begin
        cnt_q      <= '0;
        best_vld_q <= 1'b0;
        first_q    <= 1'b0;
        lw_q       <= best_w_q;
        lidx_q     <= best_idx_q;
        k_q        <= k_q + 1'b1;
      end

      // output register
      if (emit)     out_vld_q <= 1'b1;
      else if (pop) out_vld_q <= 1'b0;
    end
  end

endmodule

// ===== rtl/weighted_slot_table_priority_order.sv =====
// top level of the weighted slot table with ordered dispatch
//
//   channel   handshake            payload
//   input     push / full          in_word_i  (func, group_id, weight)
//   result    empty / pop          out_word_o (status, slot_index, slot_group_id, last)
//
// attach, detach and set weight read the table once per slot (id 0 skips the
// scan); dispatch makes one full scan of the id/weight memories per emitted word.
// reset clears the occupancy bits at once; no clearing pass is needed.
// a two-entry command queue and a one-word output register let input and
// result sides stall independently.
module weighted_slot_table_priority_order #(
  parameter int unsigned Slots = wstpo_pkg::SlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  wstpo_pkg::in_word_t  in_word_i,
  output logic                 empty,
  input  logic                 pop,
  output wstpo_pkg::out_word_t out_word_o
);

  logic            cmd_valid, cmd_ready;
  wstpo_pkg::cmd_t cmd;

  // command intake
  wstpo_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_word_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // table engine
  wstpo_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .empty, .pop, .out_word_o
  );

endmodule

// ===== dv/tb_weighted_slot_table_priority_order.sv =====
// testbench for the weighted slot table: directed and random table commands checked against an inline predictor
module tb_weighted_slot_table_priority_order;
  import wstpo_pkg::*;

  localparam int unsigned NSlots = 64;
  localparam logic [SlotIdxW-1:0] NoSlot = 7'd64;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word_o;

  weighted_slot_table_priority_order u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .empty     (empty),
    .pop       (pop),
    .out_word_o(out_word_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the table
  logic [IdW-1:0]     tbl_id  [NSlots];
  logic [WeightW-1:0] tbl_wt  [NSlots];
  out_word_t          exp_words[$];
  in_word_t           pending_words[$];
  logic [IdW-1:0]     id_pool[8];
  int                 n_errors = 0;
  int                 n_checked = 0;
  int                 n_dispatch = 0;
  bit                 quiet_phase = 1'b0;
  bit                 hold_sender = 1'b0;
  int                 send_gap = 0;
  int                 recv_gap = 0;

  function automatic out_word_t mk_word(logic [StatusW-1:0] st, logic [SlotIdxW-1:0] idx,
                                        logic [IdW-1:0] gid, logic lst);
    out_word_t w;
    w.status = st;
    w.slot_index = idx;
    w.slot_group_id = gid;
    w.last = lst;
    return w;
  endfunction

  // apply one command to the table and queue the words it should produce
  task automatic predict_table_op(input in_word_t w);
    int hit;
    int free_slot;
    int order[$];
    int pos;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < NSlots; i++) begin
      if (hit < 0 && w.group_id != '0 && tbl_id[i] == w.group_id) hit = i;
      if (free_slot < 0 && tbl_id[i] == '0) free_slot = i;
    end
    case (func_e'(w.func))
      FUNC_ATTACH: begin
        if (w.group_id == '0) exp_words.push_back(mk_word(ST_ALREADY, NoSlot, '0, 1'b1));
        else if (hit >= 0) exp_words.push_back(mk_word(ST_ALREADY, hit[6:0], '0, 1'b1));
        else if (free_slot < 0) exp_words.push_back(mk_word(ST_FULL, NoSlot, '0, 1'b1));
        else begin
          tbl_id[free_slot] = w.group_id;
          tbl_wt[free_slot] = w.weight;
          exp_words.push_back(mk_word(ST_OK, free_slot[6:0], '0, 1'b1));
        end
      end
      FUNC_DETACH, FUNC_SET_WT: begin
        if (hit < 0) exp_words.push_back(mk_word(ST_ABSENT, NoSlot, '0, 1'b1));
        else begin
          if (func_e'(w.func) == FUNC_DETACH) begin
            tbl_id[hit] = '0;
            tbl_wt[hit] = '0;
          end else tbl_wt[hit] = w.weight;
          exp_words.push_back(mk_word(ST_OK, hit[6:0], '0, 1'b1));
        end
      end
      default: begin
        n_dispatch++;
        // insertion sort: heavier first, lower slot wins ties
        for (int i = 0; i < NSlots; i++) begin
          if (tbl_id[i] == '0) continue;
          pos = order.size();
          while (pos > 0 && tbl_wt[order[pos-1]] < tbl_wt[i]) pos--;
          order.insert(pos, i);
        end
        if (order.size() == 0) exp_words.push_back(mk_word(ST_EMPTY, NoSlot, '0, 1'b1));
        foreach (order[k])
          exp_words.push_back(mk_word(ST_OK, order[k][6:0], tbl_id[order[k]],
                                      k == order.size() - 1));
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_table_op(in_word_i);
        void'(pending_words.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (hold_sender || pending_words.size() == 0) begin
        push <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(1, 11) - 1;
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_word_i <= pending_words[0];
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        n_checked++;
        if (exp_words.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word %p", $time, out_word_o);
        end else begin
          out_word_t e;
          e = exp_words.pop_front();
          if (e.status !== out_word_o.status) begin
            n_errors++;
            $display("%0t: status exp %0d got %0d", $time, e.status, out_word_o.status);
          end
          if (e.slot_index !== out_word_o.slot_index) begin
            n_errors++;
            $display("%0t: slot_index exp %0d got %0d", $time, e.slot_index,
                     out_word_o.slot_index);
          end
          if (e.slot_group_id !== out_word_o.slot_group_id) begin
            n_errors++;
            $display("%0t: slot_group_id exp %h got %h", $time, e.slot_group_id,
                     out_word_o.slot_group_id);
          end
          if (e.last !== out_word_o.last) begin
            n_errors++;
            $display("%0t: last exp %0d got %0d", $time, e.last, out_word_o.last);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  function automatic in_word_t cmd(func_e f, logic [IdW-1:0] gid, logic [WeightW-1:0] wt);
    in_word_t w;
    w.func = f;
    w.group_id = gid;
    w.weight = wt;
    return w;
  endfunction

  function automatic logic [IdW-1:0] rand_id();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    if ($urandom_range(0, 19) == 0) return '0;
    return id_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [WeightW-1:0] rand_wt();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || exp_words.size() != 0) @(posedge clk_i);
    repeat (8 * NSlots) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    func_e f;
    for (int i = 0; i < NSlots; i++) begin
      tbl_id[i] = '0;
      tbl_wt[i] = '0;
    end
    id_pool[0] = 64'hffff_ffff_ffff_ffff;
    id_pool[1] = 64'h1;
    for (int i = 2; i < 8; i++) id_pool[i] = {$urandom, $urandom} | 64'h1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty dispatch, reserved id, extremes, ties, absent ids
    pending_words.push_back(cmd(FUNC_DISPATCH, '0, '0));
    pending_words.push_back(cmd(FUNC_ATTACH, '0, 16'h5));
    pending_words.push_back(cmd(FUNC_DETACH, '0, '0));
    pending_words.push_back(cmd(FUNC_SET_WT, '0, 16'h1));
    pending_words.push_back(cmd(FUNC_DETACH, 64'h1, '0));
    pending_words.push_back(cmd(FUNC_SET_WT, 64'h1, 16'h7));
    pending_words.push_back(cmd(FUNC_ATTACH, 64'hffff_ffff_ffff_ffff, 16'hffff));
    pending_words.push_back(cmd(FUNC_ATTACH, 64'h1, 16'h0));
    pending_words.push_back(cmd(FUNC_ATTACH, 64'h2, 16'hffff));
    pending_words.push_back(cmd(FUNC_ATTACH, 64'h1, 16'h9));
    pending_words.push_back(cmd(FUNC_DISPATCH, {$urandom, $urandom}, 16'($urandom)));
    pending_words.push_back(cmd(FUNC_SET_WT, 64'h1, 16'hffff));
    pending_words.push_back(cmd(FUNC_DISPATCH, '0, '0));
    pending_words.push_back(cmd(FUNC_DETACH, 64'h2, '0));
    pending_words.push_back(cmd(FUNC_ATTACH, 64'h3, 16'h0));
    pending_words.push_back(cmd(FUNC_DISPATCH, '0, '0));
    drain();

    // fill the table, overflow it, dispatch the full table
    for (int i = 0; i < NSlots + 2; i++)
      pending_words.push_back(cmd(FUNC_ATTACH, 64'h100 + i, 16'($urandom_range(0, 3))));
    pending_words.push_back(cmd(FUNC_DISPATCH, '0, '0));
    for (int i = 0; i < NSlots; i += 2) pending_words.push_back(cmd(FUNC_DETACH, 64'h100 + i, '0));
    // sender holds until the whole backlog has drained
    while (pending_words.size() != 0) @(posedge clk_i);
    hold_sender = 1'b1;
    while (exp_words.size() != 0) @(posedge clk_i);
    hold_sender = 1'b0;
    pending_words.push_back(cmd(FUNC_ATTACH, 64'h55, 16'h8000));
    pending_words.push_back(cmd(FUNC_DISPATCH, '0, '0));
    for (int i = 1; i < NSlots + 2; i += 2) pending_words.push_back(cmd(FUNC_DETACH, 64'h100 + i, '0));
    pending_words.push_back(cmd(FUNC_DETACH, 64'h55, '0));
    drain();

    // random traffic over a small id pool so that hits dominate
    for (int n = 0; n < 260; n++) begin
      if (n == 200) begin
        drain();
        quiet_phase = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: f = FUNC_ATTACH;
        4, 5: f = FUNC_DETACH;
        6, 7, 8: f = FUNC_SET_WT;
        default: f = FUNC_DISPATCH;
      endcase
      pending_words.push_back(cmd(f, rand_id(), rand_wt()));
    end
    drain();
    $display("covered %0d result words, %0d dispatches, empty and full table, reserved id",
             n_checked, n_dispatch);
    if (n_errors == 0) $display("weighted_slot_table_priority_order verification clean");
    else $display("weighted_slot_table_priority_order verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("weighted_slot_table_priority_order verification failed");
    $finish;
  end

endmodule

// ===== weighted_slot_table_priority_order.f =====
rtl/wstpo_pkg.sv
rtl/wstpo_ram.sv
rtl/wstpo_front.sv
rtl/wstpo_back.sv
rtl/weighted_slot_table_priority_order.sv
dv/tb_weighted_slot_table_priority_order.sv
